### hw/rtl/rbpd_pkg.sv
// Shared types and constants of the packet deframer.
`timescale 1ns / 1ps
`default_nettype none
package rbpd_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_QUERY = 2'd1,
        OP_READ  = 2'd2,
        OP_SKIP  = 2'd3
    } t_op;

    localparam logic [2:0] REG_MARKER_MAIN    = 3'd0;
    localparam logic [2:0] REG_MARKER_SYNC    = 3'd1;
    localparam logic [2:0] REG_FRAME_OVERHEAD = 3'd2;
    localparam logic [2:0] REG_LENGTH_OFFSET  = 3'd3;
    localparam logic [2:0] REG_MAX_PACKET_LEN = 3'd4;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data_byte;
        logic        burst_first;
        logic [11:0] burst_len;
    } t_cmd;

    typedef struct packed {
        logic [7:0] marker_main;
        logic [7:0] marker_sync;
        logic [6:0] frame_overhead;
        logic [5:0] length_offset;
        logic [6:0] max_packet_len;
    } t_cfg;

    typedef struct packed {
        logic        status;
        logic [6:0]  pkt_len;
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic [11:0] dropped_count;
        logic [11:0] fill_level;
    } t_res;

endpackage
`default_nettype wire

### hw/rtl/rbpd_front.sv
// Request queue: accepts and classifies requests ahead of the engine.
`timescale 1ns / 1ps
`default_nettype none
module rbpd_front import rbpd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_burst_first,
    input  wire logic [11:0] i_burst_len,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_pop
);
    t_cmd        r_q [4];
    logic [1:0]  r_wr;
    logic [1:0]  r_rd;
    logic [2:0]  r_cnt;
    logic        wr_en;
    logic        rd_en;
    t_cmd        cmd_in;

    always_comb begin
        cmd_in.op          = t_op'(i_req_type);
        cmd_in.data_byte   = i_data_byte;
        cmd_in.burst_first = i_burst_first;
        cmd_in.burst_len   = i_burst_len;
    end

    assign full        = (r_cnt == 3'd4);
    assign wr_en       = push && !full;
    assign o_cmd_valid = (r_cnt != 3'd0);
    assign rd_en       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= r_wr + 2'd1;
            if (rd_en) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + {2'b00, wr_en} - {2'b00, rd_en};
        end
    end
endmodule
`default_nettype wire

### hw/rtl/rbpd_engine.sv
// Ring store, marker search sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module rbpd_engine import rbpd_pkg::*; #(
    parameter int DEPTH   = 2048,
    parameter int MAX_PKT = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_res      o_res
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + 13;
    localparam int PW = AW + 7;

    typedef enum logic [3:0] {
        S_IDLE, S_HEAD, S_HCHK, S_POS, S_HI, S_LO, S_EMIT, S_BRD, S_BOUT
    } t_state;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head, r_tail, n_tail, r_p, n_p;
    logic [CW-1:0] r_count, n_count, r_drop, n_drop;
    logic          r_burst, n_burst;
    t_op           r_op, n_op;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_hi, n_hi;
    logic          r_status, n_status;
    logic [6:0]    r_len, n_len, r_idx, n_idx;
    logic          r_out_valid;
    t_res          r_out;

    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic          out_load;
    t_res          out_d;
    logic          slot_free;
    logic [6:0]    ov, maxl;
    logic          acc, ok, avail, lst;
    logic [XW-1:0] skip_n;
    logic [AW:0]   skip_h;
    logic [16:0]   needed;

    assign ov   = (i_cfg.frame_overhead < 7'd2) ? 7'd2 : i_cfg.frame_overhead;
    assign maxl = (i_cfg.max_packet_len > 7'(MAX_PKT)) ? 7'(MAX_PKT) : i_cfg.max_packet_len;
    assign slot_free = !r_out_valid || i_pop;
    assign o_empty   = !r_out_valid;
    assign o_res     = r_out;

    always_comb begin
        n_state = r_state;  n_head = r_head;   n_tail = r_tail;  n_p = r_p;
        n_count = r_count;  n_drop = r_drop;   n_burst = r_burst; n_op = r_op;
        n_pos = r_pos;      n_hi = r_hi;       n_status = r_status;
        n_len = r_len;      n_idx = r_idx;
        rd_addr = r_head;   mem_we = 1'b0;     o_cmd_pop = 1'b0;
        out_load = 1'b0;    out_d = '0;
        acc = 1'b0;         ok = 1'b0;         avail = 1'b0;  lst = 1'b0;
        skip_n = '0;        skip_h = '0;
        needed = 17'({r_hi, r_rd_data}) + 17'(ov);
        out_d.dropped_count = 12'(r_drop);
        out_d.fill_level    = 12'(r_count);
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_PUSH: begin
                            if (slot_free) begin
                                o_cmd_pop = 1'b1;
                                acc = i_cmd.burst_first ?
                                    ((XW'(DEPTH) - XW'(r_count)) >= XW'(i_cmd.burst_len)) :
                                    r_burst;
                                ok = acc && (r_count < CW'(DEPTH));
                                n_burst = acc;
                                if (ok) begin
                                    mem_we  = 1'b1;
                                    n_tail  = f_next(r_tail);
                                    n_count = r_count + 1'b1;
                                end
                                out_load = 1'b1;
                                out_d.status = !ok;
                                out_d.last = 1'b1;
                                out_d.dropped_count = '0;
                                out_d.fill_level = 12'(n_count);
                            end
                        end
                        OP_SKIP: begin
                            if (slot_free) begin
                                o_cmd_pop = 1'b1;
                                skip_n = (XW'(i_cmd.burst_len) < XW'(r_count)) ?
                                    XW'(i_cmd.burst_len) : XW'(r_count);
                                skip_h = (AW+1)'(r_head) + (AW+1)'(skip_n);
                                if (skip_h >= (AW+1)'(DEPTH)) skip_h = skip_h - (AW+1)'(DEPTH);
                                n_head  = skip_h[AW-1:0];
                                n_count = r_count - CW'(skip_n);
                                out_load = 1'b1;
                                out_d.last = 1'b1;
                                out_d.dropped_count = 12'(skip_n);
                                out_d.fill_level = 12'(n_count);
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                            n_op = i_cmd.op;
                            n_drop = '0;
                            n_state = S_HEAD;
                        end
                    endcase
                end
            end
            S_HEAD: begin
                n_state = S_HCHK;
            end
            S_HCHK: begin
                if (XW'(r_count) < XW'(ov)) begin
                    n_status = 1'b1;
                    n_len = '0;
                    n_state = S_EMIT;
                end else if (r_rd_data != i_cfg.marker_main &&
                             r_rd_data != i_cfg.marker_sync) begin
                    // drop the head byte and look again
                    n_head  = f_next(r_head);
                    n_count = r_count - 1'b1;
                    n_drop  = r_drop + 1'b1;
                    n_state = S_HEAD;
                end else begin
                    n_pos = PW'(r_head) + PW'(i_cfg.length_offset);
                    n_state = S_POS;
                end
            end
            S_POS: begin
                rd_addr = r_pos[AW-1:0];
                if (r_pos >= PW'(DEPTH)) begin
                    n_pos = r_pos - PW'(DEPTH);
                end else begin
                    n_state = S_HI;
                end
            end
            S_HI: begin
                n_hi = r_rd_data;
                rd_addr = f_next(r_pos[AW-1:0]);
                n_state = S_LO;
            end
            S_LO: begin
                if (needed > 17'(maxl)) begin
                    n_head  = f_next(r_head);
                    n_count = r_count - 1'b1;
                    n_drop  = r_drop + 1'b1;
                    n_status = 1'b1;
                    n_len = '0;
                    n_state = S_EMIT;
                end else begin
                    avail = XW'(needed) <= XW'(r_count);
                    n_len = needed[6:0];
                    if (r_op == OP_QUERY || !avail) begin
                        n_status = !avail;
                        n_state = S_EMIT;
                    end else begin
                        n_p = r_head;
                        n_idx = '0;
                        n_state = S_BRD;
                    end
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    out_d.status = r_status;
                    out_d.pkt_len = r_len;
                    out_d.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BRD: begin
                rd_addr = r_p;
                n_state = S_BOUT;
            end
            S_BOUT: begin
                // hold the read address so the byte survives a stall
                rd_addr = r_p;
                if (slot_free) begin
                    lst = (r_idx + 7'd1) == r_len;
                    out_load = 1'b1;
                    out_d.pkt_len = r_len;
                    out_d.out_byte = r_rd_data;
                    out_d.byte_valid = 1'b1;
                    out_d.last = lst;
                    n_p = f_next(r_p);
                    n_idx = r_idx + 7'd1;
                    n_state = lst ? S_IDLE : S_BRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= i_cmd.data_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;  r_drop <= n_drop;  r_op <= n_op;  r_pos <= n_pos;
        r_hi <= n_hi;  r_status <= n_status;  r_len <= n_len;  r_idx <= n_idx;
        if (out_load) r_out <= out_d;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0;
            r_tail <= '0;
            r_count <= '0;
            r_burst <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_tail <= n_tail;
            r_count <= n_count;
            r_burst <= n_burst;
            if (out_load) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("fill count above depth");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BOUT) |-> (r_idx < r_len)) else $error("readout past packet end");
    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_tail)) else $error("tail moved during search");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> slot_free) else $error("result overwritten");
endmodule
`default_nettype wire

### hw/rtl/ring_buffer_packet_deframer_core.sv
// Top level of the length-prefixed packet deframer on a byte ring.
// Requests enter through a queue port: push with full, four deep. Request types are
// push byte, query packet, read packet and skip bytes. Results leave through a queue
// port: empty with pop, one result register; a read of an available packet gives one
// result per packet byte, every other request gives one result marked last.
// Configuration registers are written on the cfg channel, ready always high; the user
// must write them only while no request is pending, the block does not enforce it.
// Push and skip are served in the idle state once the result register is free. Query
// and read pass the head read and head check states per byte dropped at the head in the
// marker search, then the offset wrap and the two length reads; readout alternates a
// read state and an output state per packet byte, set by the ring store's single registered read port.
// Reset clears the ring pointers, the fill count and the burst admission; stored
// bytes are not cleared. A stalled receiver holds the result register, the
// engine waits on it and the request queue fills and raises full.
`timescale 1ns / 1ps
`default_nettype none
module ring_buffer_packet_deframer_core import rbpd_pkg::*; #(
    parameter int DEPTH   = 2048,
    parameter int MAX_PKT = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_burst_first,
    input  wire logic [11:0] i_burst_len,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_status,
    output logic [6:0]       o_pkt_len,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_last,
    output logic [11:0]      o_dropped_count,
    output logic [11:0]      o_fill_level,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    t_cfg r_cfg;
    logic cmd_valid, cmd_pop;
    t_cmd cmd;
    t_res res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.marker_main    <= 8'd0;
            r_cfg.marker_sync    <= 8'd0;
            r_cfg.frame_overhead <= 7'd6;
            r_cfg.length_offset  <= 6'd2;
            r_cfg.max_packet_len <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MARKER_MAIN:    r_cfg.marker_main    <= i_cfg_data;
                REG_MARKER_SYNC:    r_cfg.marker_sync    <= i_cfg_data;
                REG_FRAME_OVERHEAD: r_cfg.frame_overhead <= i_cfg_data[6:0];
                REG_LENGTH_OFFSET:  r_cfg.length_offset  <= i_cfg_data[5:0];
                REG_MAX_PACKET_LEN: r_cfg.max_packet_len <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    rbpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_req_type    (i_req_type),
        .i_data_byte   (i_data_byte),
        .i_burst_first (i_burst_first),
        .i_burst_len   (i_burst_len),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    rbpd_engine #(
        .DEPTH   (DEPTH),
        .MAX_PKT (MAX_PKT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_status        = res.status;
    assign o_pkt_len       = res.pkt_len;
    assign o_out_byte      = res.out_byte;
    assign o_byte_valid    = res.byte_valid;
    assign o_last          = res.last;
    assign o_dropped_count = res.dropped_count;
    assign o_fill_level    = res.fill_level;
endmodule
`default_nettype wire

### tb/sv/ring_buffer_packet_deframer_core_test.sv
// Self-checking testbench for the packet deframer core: predictor, scoreboard and drivers.
`timescale 1ns / 1ps
`default_nettype none
module ring_buffer_packet_deframer_core_test;
    import rbpd_pkg::*;

    localparam int RING_DEPTH = 2048;
    localparam int PKT_CAP = 64;
    localparam longint CYCLE_LIMIT = 20000000;

    // Deframer predictor: ring contents, pointers and registers of its own.
    class deframer_scoreboard;
        logic [7:0]  ring [RING_DEPTH];
        int unsigned head, tail, fill;
        bit          admitted;
        logic [7:0]  mk_main, mk_sync;
        logic [6:0]  overhead, max_len;
        logic [5:0]  len_off;
        t_res        pending [$];
        int          mismatches;
        int          results_seen;

        function void clear();
            foreach (ring[i]) ring[i] = 8'h00;
            head = 0; tail = 0; fill = 0; admitted = 0;
            mk_main = 0; mk_sync = 0; overhead = 6; len_off = 2; max_len = 64;
            pending.delete();
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                REG_MARKER_MAIN:    mk_main = val;
                REG_MARKER_SYNC:    mk_sync = val;
                REG_FRAME_OVERHEAD: overhead = val[6:0];
                REG_LENGTH_OFFSET:  len_off = val[5:0];
                REG_MAX_PACKET_LEN: max_len = val[6:0];
                default: ;
            endcase
        endfunction

        function void note(t_res r);
            pending.push_back(r);
        endfunction

        function void drop_one(ref int unsigned dropped);
            head = (head + 1) % RING_DEPTH;
            fill--;
            dropped++;
        endfunction

        function t_res make(bit st, int unsigned len, logic [7:0] b, bit bv, bit lst,
                            int unsigned dropped);
            t_res r;
            r.status = st; r.pkt_len = len[6:0]; r.out_byte = b; r.byte_valid = bv;
            r.last = lst; r.dropped_count = dropped[11:0]; r.fill_level = fill[11:0];
            return r;
        endfunction

        function void note_request(t_cmd c);
            int unsigned dropped, ov, lim, pos, needed, n, p;
            bit ok, avail;
            dropped = 0;
            case (c.op)
                OP_PUSH: begin
                    if (c.burst_first) admitted = (RING_DEPTH - fill) >= c.burst_len;
                    ok = admitted && fill < RING_DEPTH;
                    if (ok) begin
                        ring[tail] = c.data_byte;
                        tail = (tail + 1) % RING_DEPTH;
                        fill++;
                    end
                    note(make(!ok, 0, 0, 0, 1, 0));
                end
                OP_SKIP: begin
                    n = c.burst_len < fill ? c.burst_len : fill;
                    repeat (n) drop_one(dropped);
                    note(make(0, 0, 0, 0, 1, dropped));
                end
                default: begin
                    ov = overhead < 2 ? 2 : overhead;
                    lim = max_len > PKT_CAP ? PKT_CAP : max_len;
                    avail = 0;
                    needed = 0;
                    while (fill >= ov && ring[head] != mk_main && ring[head] != mk_sync)
                        drop_one(dropped);
                    if (fill >= ov) begin
                        pos = (head + len_off) % RING_DEPTH;
                        needed = {ring[pos], ring[(pos + 1) % RING_DEPTH]} + ov;
                        if (needed > lim) begin
                            drop_one(dropped);
                            needed = 0;
                        end else begin
                            avail = needed <= fill;
                        end
                    end
                    if (c.op == OP_QUERY || !avail) begin
                        note(make(!avail, needed, 0, 0, 1, dropped));
                    end else begin
                        p = head;
                        for (int i = 0; i < needed; i++) begin
                            note(make(0, needed, ring[p], 1, i + 1 == needed, dropped));
                            p = (p + 1) % RING_DEPTH;
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(t_res got);
            t_res want;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_req_type;
    logic [7:0]  i_data_byte;
    logic        i_burst_first;
    logic [11:0] i_burst_len;
    logic        empty;
    logic        pop;
    logic        o_status;
    logic [6:0]  o_pkt_len;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_last;
    logic [11:0] o_dropped_count;
    logic [11:0] o_fill_level;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    deframer_scoreboard board;
    longint cycles;
    int     requests_sent;
    bit     timed_out;

    ring_buffer_packet_deframer_core i_dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, sample results at the edge of the transfer.
    initial begin
        int wait_n;
        pop = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_n != 0) begin
                pop <= 0;
                repeat (wait_n) @(posedge i_clk);
            end
            pop <= 1;
            do @(posedge i_clk); while (empty);
            board.check_result('{o_status, o_pkt_len, o_out_byte, o_byte_valid, o_last,
                                 o_dropped_count, o_fill_level});
        end
    end

    // Push stays high into the next transfer when no gap is drawn.
    task automatic send(t_cmd c, bit no_gap = 0);
        int gap;
        gap = (!no_gap && $urandom_range(0, 3) != 0) ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1;
        i_req_type <= c.op;
        i_data_byte <= c.data_byte;
        i_burst_first <= c.burst_first;
        i_burst_len <= c.burst_len;
        do @(posedge i_clk); while (full);
        board.note_request(c);
        requests_sent++;
    endtask

    task automatic drain();
        push <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        // hold for in-flight marker search that yields nothing further
        repeat (4300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, val);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_cmd cmd(t_op op, logic [7:0] d, bit f, logic [11:0] n);
        t_cmd c;
        c.op = op; c.data_byte = d; c.burst_first = f; c.burst_len = n;
        return c;
    endfunction

    // Well-formed frame as a burst, content random, length field at len_off.
    task automatic send_frame(logic [7:0] mk, int unsigned body, output int sent);
        int unsigned ov, total;
        logic [7:0] b;
        ov = board.overhead < 2 ? 2 : board.overhead;
        total = body + ov;
        if (total < board.len_off + 2) total = board.len_off + 2;
        for (int i = 0; i < total; i++) begin
            b = 8'($urandom);
            if (i == 0) b = mk;
            else if (i == board.len_off) b = 8'h00;
            else if (i == board.len_off + 1) b = body[7:0];
            send(cmd(OP_PUSH, b, i == 0, total[11:0]), $urandom_range(0, 2) == 0);
        end
        sent = int'(total);
    endtask

    task automatic random_phase(int count);
        int k;
        int sent;
        int unsigned r;
        k = 0;
        while (k < count) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_frame($urandom_range(0, 1) ? board.mk_main : board.mk_sync,
                           $urandom_range(0, 12), sent);
                k += sent;
            end else if (r < 50) begin
                send(cmd(OP_PUSH, 8'($urandom), 1'($urandom), 12'($urandom_range(0, 4095))));
                k++;
            end else if (r < 70) begin
                send(cmd(OP_READ, 8'($urandom), 1'($urandom), 12'($urandom)));
                k++;
            end else if (r < 85) begin
                send(cmd(OP_QUERY, 8'($urandom), 1'($urandom), 12'($urandom)));
                k++;
            end else begin
                send(cmd(OP_SKIP, 8'($urandom), 1'($urandom),
                         12'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 8))));
                k++;
            end
        end
    endtask

    initial begin
        board = new();
        board.clear();
        cycles = 0; requests_sent = 0; timed_out = 0;
        i_rst_n = 0; push = 0; i_req_type = OP_PUSH; i_data_byte = 0;
        i_burst_first = 0; i_burst_len = 0;
        i_cfg_valid = 0; i_cfg_index = REG_MARKER_MAIN; i_cfg_data = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty queries, refusals, zero-length burst, extremes, each op.
        send(cmd(OP_QUERY, 0, 0, 0));
        send(cmd(OP_READ, 0, 0, 0));
        send(cmd(OP_SKIP, 8'hff, 1, 12'hfff));
        send(cmd(OP_PUSH, 8'hff, 1, 12'hfff));
        send(cmd(OP_PUSH, 8'h00, 0, 0));
        send(cmd(OP_PUSH, 8'h55, 1, 0));
        send(cmd(OP_PUSH, 8'haa, 0, 12'hfff));
        send(cmd(OP_PUSH, 8'h00, 1, 12'd800));
        for (int i = 0; i < 9; i++) send(cmd(OP_PUSH, i == 3 ? 8'h02 : 8'h00, 0, 0));
        send(cmd(OP_QUERY, 0, 0, 0));
        send(cmd(OP_READ, 8'hff, 1, 12'hfff));
        send(cmd(OP_SKIP, 0, 0, 12'd1));
        send(cmd(OP_READ, 0, 0, 0));
        send(cmd(OP_SKIP, 0, 0, 12'd2048));
        drain();

        // Saturation extremes: overhead below two, maximum above the cap.
        write_reg(REG_FRAME_OVERHEAD, 8'd0);
        write_reg(REG_MAX_PACKET_LEN, 8'd127);
        write_reg(REG_MARKER_MAIN, 8'hff);
        write_reg(REG_MARKER_SYNC, 8'h00);
        write_reg(REG_LENGTH_OFFSET, 8'd0);
        random_phase(60);
        drain();

        write_reg(REG_FRAME_OVERHEAD, 8'd64);
        write_reg(REG_MAX_PACKET_LEN, 8'd2);
        write_reg(REG_LENGTH_OFFSET, 8'd62);
        write_reg(REG_MARKER_MAIN, 8'h7e);
        random_phase(20);
        drain();

        write_reg(REG_FRAME_OVERHEAD, 8'd6);
        write_reg(REG_MAX_PACKET_LEN, 8'd64);
        write_reg(REG_LENGTH_OFFSET, 8'd2);
        write_reg(REG_MARKER_MAIN, 8'ha5);
        write_reg(REG_MARKER_SYNC, 8'h5a);
        random_phase(90);
        drain();

        write_reg(REG_FRAME_OVERHEAD, 8'd3);
        write_reg(REG_MAX_PACKET_LEN, 8'd20);
        write_reg(REG_LENGTH_OFFSET, 8'd1);
        random_phase(90);

        drain();
        $display("Sent %0d requests, checked %0d results over %0d cycles,",
                 requests_sent, board.results_seen, cycles);
        $display("covering marker search, oversized lengths, readout and burst refusal.");
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
